/* sv/uhst_pkg.sv */
// Shared constants, operation codes and cell interface types for the handle slot table.
`default_nettype none

package uhst_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int HDL_W  = 32;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_FIND       = 2'd2,
        OP_GET        = 2'd3
    } t_op;

    // write command to one cell
    typedef struct packed {
        logic set;
        logic clr;
    } t_cell_cmd;

    // status from one cell
    typedef struct packed {
        logic used;
        logic hit;   // lowest occupied cell holding the handle
        logic take;  // lowest free cell
    } t_cell_stat;

endpackage

`default_nettype wire

/* sv/unique_handle_slot_table.sv */
// Top level: request register, row of slot cells, decision logic and output register.
// Result path: the request register loads at the accepting edge, then evaluation runs
//   through the cell chain into the output register.
// The table handles one item at a time: no new item is taken while one is in
//   evaluation, and the cell row is both read and written in the evaluation cycle.
// Reset (synchronous, active low): all slots free, count zero, no item pending.
`default_nettype none

module unique_handle_slot_table (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_operation,
    input  wire  [31:0] i_handle_index,
    input  wire  [31:0] i_handle_generation,
    input  wire  [3:0]  i_slot_number,
    input  wire         i_entity_alive,
    input  wire         i_has_actor,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_ok,
    output logic [2:0]  o_slot_result,
    output logic [31:0] o_found_index,
    output logic [31:0] o_found_generation,
    output logic [3:0]  o_occupied_count
);

    localparam int SLOTS  = uhst_pkg::SLOTS;
    localparam int SLOT_W = uhst_pkg::SLOT_W;
    localparam int CNT_W  = uhst_pkg::CNT_W;
    localparam int HDL_W  = uhst_pkg::HDL_W;

    // ---- request register -------------------------------------------------
    logic               r_busy;
    uhst_pkg::t_op      r_op;
    logic [HDL_W-1:0]   r_index;
    logic [HDL_W-1:0]   r_generation;
    logic [3:0]         r_sn;
    logic               r_alive;
    logic               r_actor;

    // ---- output register --------------------------------------------------
    logic               r_out_valid;
    logic               r_ok;
    logic [SLOT_W-1:0]  r_slot;
    logic [HDL_W-1:0]   r_f_index;
    logic [HDL_W-1:0]   r_f_generation;
    logic [CNT_W-1:0]   r_count;

    logic               in_acc;
    logic               out_acc;

    // A new item is taken only when nothing is in evaluation and the result
    // register is empty or being emptied this cycle.
    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op         <= uhst_pkg::t_op'(i_operation);
            r_index      <= i_handle_index;
            r_generation <= i_handle_generation;
            r_sn         <= i_slot_number;
            r_alive      <= i_entity_alive;
            r_actor      <= i_has_actor;
        end
    end

    // ---- cell row -----------------------------------------------------------
    // free_ch ripples "a lower slot is free"; found_ch ripples "a lower slot
    // already matched", so each cell knows whether it is the first of its kind.
    logic                  free_ch  [SLOTS+1];
    logic                  found_ch [SLOTS+1];
    uhst_pkg::t_cell_stat  stat     [SLOTS];
    uhst_pkg::t_cell_cmd   cmd      [SLOTS];
    logic [HDL_W-1:0]      c_index  [SLOTS];
    logic [HDL_W-1:0]      c_gen    [SLOTS];
    logic [SLOTS-1:0]      sel;

    assign free_ch[0]  = 1'b0;
    assign found_ch[0] = 1'b0;

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        assign sel[k] = ({28'd0, r_sn} == 32'(k));

        uhst_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (r_index),
            .i_generation (r_generation),
            .i_cmd        (cmd[k]),
            .i_free_in    (free_ch[k]),
            .i_found_in   (found_ch[k]),
            .o_free_out   (free_ch[k+1]),
            .o_found_out  (found_ch[k+1]),
            .o_stat       (stat[k]),
            .o_index      (c_index[k]),
            .o_generation (c_gen[k])
        );
    end

    // ---- decision -----------------------------------------------------------
    logic               in_range;
    logic               live_ok;
    logic               plausible;
    logic               any_free;
    logic               any_match;
    logic               sel_used;
    logic [HDL_W-1:0]   sel_index;
    logic [HDL_W-1:0]   sel_gen;
    logic [SLOT_W-1:0]  take_slot;
    logic [SLOT_W-1:0]  hit_slot;

    logic               n_ok;
    logic [SLOT_W-1:0]  n_slot;
    logic [HDL_W-1:0]   n_f_index;
    logic [HDL_W-1:0]   n_f_generation;
    logic               do_set;
    logic               do_clr;
    logic [CNT_W-1:0]   n_count;

    assign in_range  = ({28'd0, r_sn} < 32'(SLOTS));
    assign live_ok   = r_alive && r_actor;
    // all-ones index and zero generation can never name a live entity
    assign plausible = (r_index != '1) && (r_generation != '0);
    assign any_free  = free_ch[SLOTS];
    assign any_match = found_ch[SLOTS];

    // one-hot picks from the row, encoded and muxed by AND-OR
    always_comb begin
        sel_used  = 1'b0;
        sel_index = '0;
        sel_gen   = '0;
        take_slot = '0;
        hit_slot  = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (sel[k]) begin
                sel_used  = sel_used | stat[k].used;
                sel_index = sel_index | c_index[k];
                sel_gen   = sel_gen | c_gen[k];
            end
            if (stat[k].take) begin
                take_slot = take_slot | SLOT_W'(k);
            end
            if (stat[k].hit) begin
                hit_slot = hit_slot | SLOT_W'(k);
            end
        end
    end

    always_comb begin
        n_ok           = 1'b0;
        n_slot         = '0;
        n_f_index      = '0;
        n_f_generation = '0;
        do_set         = 1'b0;
        do_clr         = 1'b0;
        unique case (r_op)
            uhst_pkg::OP_REGISTER: begin
                if (live_ok && plausible && !any_match && any_free) begin
                    n_ok   = 1'b1;
                    n_slot = take_slot;
                    do_set = 1'b1;
                end
            end
            uhst_pkg::OP_UNREGISTER: begin
                if (in_range && sel_used) begin
                    n_ok   = 1'b1;
                    do_clr = 1'b1;
                end
            end
            uhst_pkg::OP_FIND: begin
                if (live_ok && any_match) begin
                    n_ok   = 1'b1;
                    n_slot = hit_slot;
                end
            end
            uhst_pkg::OP_GET: begin
                if (in_range && sel_used && live_ok) begin
                    n_ok           = 1'b1;
                    n_f_index      = sel_index;
                    n_f_generation = sel_gen;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // cells are written only in the evaluation cycle
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            cmd[k].set = r_busy && do_set && stat[k].take;
            cmd[k].clr = r_busy && do_clr && sel[k];
        end
    end

    assign n_count = r_count + CNT_W'(do_set) - CNT_W'(do_clr);

    // ---- result register ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else if (r_busy) begin
            r_out_valid <= 1'b1;
            r_count     <= n_count;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_ok           <= n_ok;
            r_slot         <= n_slot;
            r_f_index      <= n_f_index;
            r_f_generation <= n_f_generation;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_ok               = r_ok;
    assign o_slot_result      = 3'(r_slot);
    assign o_found_index      = r_f_index;
    assign o_found_generation = r_f_generation;
    assign o_occupied_count   = 4'(r_count);

endmodule

`default_nettype wire

/* sv/uhst_cell.sv */
// One slot of the table: occupied mark, stored handle, local match and first-free chain.
`default_nettype none

module uhst_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire [uhst_pkg::HDL_W-1:0] i_index,
    input  wire [uhst_pkg::HDL_W-1:0] i_generation,
    input  uhst_pkg::t_cell_cmd      i_cmd,
    input  wire                      i_free_in,
    input  wire                      i_found_in,
    output logic                     o_free_out,
    output logic                     o_found_out,
    output uhst_pkg::t_cell_stat     o_stat,
    output logic [uhst_pkg::HDL_W-1:0] o_index,
    output logic [uhst_pkg::HDL_W-1:0] o_generation
);

    logic                       r_used;
    logic [uhst_pkg::HDL_W-1:0] r_index;
    logic [uhst_pkg::HDL_W-1:0] r_generation;
    logic                       match;

    assign match       = r_used && (r_index == i_index) && (r_generation == i_generation);
    assign o_found_out = i_found_in | match;
    assign o_free_out  = i_free_in | ~r_used;

    always_comb begin
        o_stat.used = r_used;
        o_stat.hit  = match && !i_found_in;
        o_stat.take = !r_used && !i_free_in;
    end

    assign o_index      = r_index;
    assign o_generation = r_generation;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.set) begin
            r_used <= 1'b1;
        end else if (i_cmd.clr) begin
            r_used <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set) begin
            r_index      <= i_index;
            r_generation <= i_generation;
        end else if (i_cmd.clr) begin
            r_index      <= '0;
            r_generation <= '0;
        end
    end

endmodule

`default_nettype wire

/* sv/uhst_checker.sv */
// Port-level checks for the handle slot table, bound to the top level.
`default_nettype none

module uhst_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire        o_ok,
    input wire [2:0]  o_slot_result,
    input wire [31:0] o_found_index,
    input wire [31:0] o_found_generation,
    input wire [3:0]  o_occupied_count
);

    // one item at a time: an accepted item blocks the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while previous one in evaluation");

    // a failed result carries no slot and no handle
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_slot_result == 3'd0 && o_found_index == 32'd0
                                    && o_found_generation == 32'd0))
        else $error("failed result with nonzero payload");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // occupied count never exceeds the number of slots
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupied_count <= 4'(uhst_pkg::SLOTS)))
        else $error("occupied count above slot total");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind unique_handle_slot_table uhst_checker u_uhst_checker (.*);

`default_nettype wire
